FILE: sv/flow_pair_bucket_hash_top_assert.svh
// Assertion macros used by the flow pair bucket hash top module.
`ifndef FLOW_PAIR_BUCKET_HASH_TOP_ASSERT_SVH
`define FLOW_PAIR_BUCKET_HASH_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPBH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FPBH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/fpbh_pkg.sv
package fpbh_pkg;

    localparam logic [63:0] FNV_BASIS       = 64'hcbf2_9ce4_8422_2325;
    // The FNV prime is 2^40 + 0x1B3, so the product is a shift plus a small constant multiply.
    localparam logic [8:0]  FNV_PRIME_LO    = 9'h1B3;
    localparam int          FNV_PRIME_SHIFT = 40;
    localparam logic [63:0] ALL_ONES        = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam int KEY_BYTES  = 8;
    localparam int BYTE_CNT_W = $clog2(KEY_BYTES + 1);

    localparam int          TRY_W        = 11;
    localparam logic [10:0] REJECT_LIMIT = 11'd1024;

    localparam int DIV_STEPS = 2;
    localparam int DIV_ITERS = 64 / DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_ITERS);

    localparam logic [32:0] SIZE_RESET = 33'd1024;
    localparam logic [32:0] SIZE_MAX   = 33'h1_0000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_REJ,
        S_MOD,
        S_OUT
    } t_state;

    // Zero means one bucket; anything above 2^32 saturates to 2^32.
    function automatic logic [32:0] eff_size(input logic [32:0] v);
        logic [32:0] r;
        if (v[32]) begin
            r = SIZE_MAX;
        end else if (v == '0) begin
            r = 33'd1;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: sv/fpbh_if.sv
interface fpbh_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;

    modport source (output valid, output src_addr, output dst_addr, input ready);
    modport sink   (input valid, input src_addr, input dst_addr, output ready);
endinterface

interface fpbh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] bucket_index;

    modport source (output valid, output bucket_index, input ready);
    modport sink   (input valid, input bucket_index, output ready);
endinterface

FILE: sv/fpbh_mac.sv
module fpbh_mac (
    input  logic [63:0] i_x,
    input  logic [63:0] i_add,
    output logic [63:0] o_y
);
    import fpbh_pkg::*;

    // x * prime + add, modulo 2^64.
    assign o_y = (i_x << FNV_PRIME_SHIFT) + (i_x * 64'(FNV_PRIME_LO)) + i_add;

endmodule

FILE: sv/fpbh_div.sv
module fpbh_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [32:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_rem
);
    import fpbh_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [63:0]          r_dvd;
    logic [31:0]          r_rem;

    logic [32:0] w_t   [DIV_STEPS];
    logic [31:0] w_rem [DIV_STEPS+1];

    // Restoring remainder, several dividend bits per cycle, most significant first.
    always_comb begin
        w_rem[0] = r_rem;
        for (int k = 0; k < DIV_STEPS; k++) begin
            w_t[k] = {w_rem[k], r_dvd[63-k]};
            if (w_t[k] >= i_divisor) begin
                w_rem[k+1] = 32'(w_t[k] - i_divisor);
            end else begin
                w_rem[k+1] = w_t[k][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CNT_W'(DIV_ITERS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_ITERS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[63-DIV_STEPS:0], {DIV_STEPS{1'b0}}};
            r_rem <= w_rem[DIV_STEPS];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: sv/flow_pair_bucket_hash_top.sv
// Flow pair bucket hash: for each item (IPv4 source and destination address) the block runs
// 64-bit FNV-1a over the eight address octets, source first and most significant octet first,
// redraws the hash as hash*prime+basis while it lies at or above the largest multiple of the
// table size below 2^64 (at most 1024 redraws), and returns the hash modulo the table size as
// the bucket index. The block works on one item at a time; the time from acceptance to
// acceptance of the next item grows with the number of redraws, which is almost always zero.
// That time is set mainly by the shared two-bit-per-cycle remainder unit, which runs twice
// per item: first for the rejection bound (2^64-1 modulo the table size, overlapped with the
// eight FNV steps on the shared multiply-add unit), then for the final modulo. Each redraw is
// one more pass through the multiply-add unit. A finished bucket index sits
// in an output register, so the next item is taken while the result still waits. The table
// size register resets to 1024, treats zero as one and saturates above 2^32; write it only
// while the block is idle.
`include "flow_pair_bucket_hash_top_assert.svh"

module flow_pair_bucket_hash_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpbh_in_if.sink     i_item,
    fpbh_out_if.source  o_result,
    input  logic        i_cfg_we,
    input  logic [32:0] i_cfg_wdata
);
    import fpbh_pkg::*;

    t_state                r_state, n_state;
    logic [32:0]           r_size;
    logic [63:0]           r_hash, n_hash;
    logic [63:0]           r_key, n_key;
    logic [BYTE_CNT_W-1:0] r_bcnt, n_bcnt;
    logic [TRY_W-1:0]      r_tries, n_tries;
    logic [63:0]           r_limit, n_limit;
    logic                  r_ovalid, n_ovalid;
    logic [31:0]           r_out, n_out;

    logic [63:0] w_mac_x;
    logic [63:0] w_mac_add;
    logic [63:0] w_mac;
    logic        w_div_start;
    logic [63:0] w_div_dvd;
    logic        w_div_done;
    logic [31:0] w_rem;

    // The multiply-add unit folds in the next key octet while hashing and adds the offset
    // basis while redrawing.
    assign w_mac_x   = (r_state == S_HASH) ? (r_hash ^ {56'd0, r_key[63:56]}) : r_hash;
    assign w_mac_add = (r_state == S_REJ) ? FNV_BASIS : 64'd0;

    fpbh_mac u_mac (
        .i_x   (w_mac_x),
        .i_add (w_mac_add),
        .o_y   (w_mac)
    );

    fpbh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (r_size),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_size   <= SIZE_RESET;
            r_ovalid <= 1'b0;
            r_bcnt   <= '0;
            r_tries  <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_bcnt   <= n_bcnt;
            r_tries  <= n_tries;
            if (i_cfg_we) begin
                r_size <= eff_size(i_cfg_wdata);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash  <= n_hash;
        r_key   <= n_key;
        r_limit <= n_limit;
        r_out   <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_key       = r_key;
        n_bcnt      = r_bcnt;
        n_tries     = r_tries;
        n_limit     = r_limit;
        n_out       = r_out;
        n_ovalid    = r_ovalid;
        w_div_start = 1'b0;
        w_div_dvd   = ALL_ONES;

        if (r_ovalid && o_result.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_hash      = FNV_BASIS;
                    n_key       = {i_item.src_addr, i_item.dst_addr};
                    n_bcnt      = '0;
                    n_tries     = '0;
                    w_div_start = 1'b1;
                    n_state     = S_HASH;
                end
            end
            S_HASH: begin
                if (r_bcnt != BYTE_CNT_W'(KEY_BYTES)) begin
                    n_hash = w_mac;
                    n_key  = {r_key[55:0], 8'd0};
                    n_bcnt = r_bcnt + 1'b1;
                end
                // The bound is the largest multiple of the size that fits in 64 bits.
                if (w_div_done) begin
                    n_limit = ALL_ONES - {32'd0, w_rem};
                    n_state = S_REJ;
                end
            end
            S_REJ: begin
                if ((r_hash >= r_limit) && (r_tries != REJECT_LIMIT)) begin
                    n_hash  = w_mac;
                    n_tries = r_tries + 1'b1;
                end else begin
                    w_div_start = 1'b1;
                    w_div_dvd   = r_hash;
                    n_state     = S_MOD;
                end
            end
            S_MOD: begin
                if (w_div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || o_result.ready) begin
                    n_out    = w_rem;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_item.ready          = (r_state == S_IDLE);
    assign o_result.valid        = r_ovalid;
    assign o_result.bucket_index = r_out;

    // The bound computation always outlasts the eight FNV steps.
    `FPBH_ASSERT_IMP(a_fnv_done_first, i_clk, i_rst_n, (r_state == S_HASH) && w_div_done, r_bcnt == BYTE_CNT_W'(KEY_BYTES), "bound ready before FNV steps finished")
    // A bucket index offered at the output is below the table size.
    `FPBH_ASSERT_IMP(a_index_in_range, i_clk, i_rst_n, r_ovalid, 33'(r_out) < r_size, "bucket index not below table size")
    // The redraw count never passes its limit.
    `FPBH_ASSERT_IMP(a_tries_bounded, i_clk, i_rst_n, 1'b1, r_tries <= REJECT_LIMIT, "redraw count above limit")
    // A hash below the bound goes straight to the final modulo.
    `FPBH_ASSERT_NXT(a_accept_hash, i_clk, i_rst_n, (r_state == S_REJ) && (r_hash < r_limit), r_state == S_MOD, "hash below bound was redrawn")

endmodule

FILE: sim/tb_flow_pair_bucket_hash_top.sv
module tb_flow_pair_bucket_hash_top;

    localparam int CLK_PERIOD     = 10;
    // A slow but correct run could spend up to 1024 redraws on every item, plus sender gaps and
    // receiver stalls. This limit is several times that worst case.
    localparam int TIMEOUT_CYCLES = 3_000_000;
    // The block is back in its idle state by the time its result has been taken.
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 60;
    localparam int MAX_PRINTED    = 200;

    localparam logic [63:0] HASH_BASIS  = 64'hcbf2_9ce4_8422_2325;
    localparam logic [63:0] HASH_PRIME  = 64'h0000_0100_0000_01b3;
    localparam logic [63:0] HASH_ALL1   = {64{1'b1}};
    localparam int          MAX_REDRAWS = 1024;
    localparam logic [32:0] SIZE_AT_RESET = 33'd1024;
    localparam logic [32:0] SIZE_2_POW_32 = 33'h1_0000_0000;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
    } t_flow_pair;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [32:0] cfg_wdata;

    fpbh_in_if  item_if ();
    fpbh_out_if result_if ();

    flow_pair_bucket_hash_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_result    (result_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Address pairs waiting to be driven, and bucket indexes predicted for accepted items
    // whose results have not arrived yet.
    t_flow_pair  pending_pairs [$];
    logic [31:0] expected_buckets [$];

    // The testbench's own copy of the table size register.
    logic [32:0] table_size_now;
    logic        pair_taken;
    int          mismatch_count = 0;

    // Sender burst state and receiver stall pattern.
    int          burst_left = 0;
    int          gap_left   = 0;
    int          stall_left = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    logic [3:0]  stall_phase = '0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Number of buckets the block actually uses: zero acts as one, and anything above 2^32
    // is clamped to 2^32.
    function automatic logic [63:0] bucket_count(input logic [32:0] size_reg);
        if (size_reg == '0) begin
            return 64'd1;
        end
        if (size_reg > SIZE_2_POW_32) begin
            return {31'd0, SIZE_2_POW_32};
        end
        return {31'd0, size_reg};
    endfunction

    // FNV-1a over the eight address octets, source first and most significant octet first.
    // Hashes in the uneven top slice of the 64-bit range are redrawn a bounded number of
    // times so that the final modulo stays unbiased, then the bucket is the remainder.
    function automatic logic [31:0] fnv_bucket(input logic [32:0] size_reg,
                                               input logic [31:0] src,
                                               input logic [31:0] dst);
        logic [63:0] buckets;
        logic [63:0] accept_below;
        logic [63:0] key;
        logic [63:0] h;
        int          k;
        int          redraws;
        buckets      = bucket_count(size_reg);
        accept_below = (HASH_ALL1 / buckets) * buckets;
        key          = {src, dst};
        h            = HASH_BASIS;
        for (k = 7; k >= 0; k--) begin
            h = (h ^ {56'd0, key[8*k +: 8]}) * HASH_PRIME;
        end
        redraws = 0;
        while (h >= accept_below && redraws < MAX_REDRAWS) begin
            h = h * HASH_PRIME + HASH_BASIS;
            redraws++;
        end
        h = h % buckets;
        return h[31:0];
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Sampling side. Everything the block shows is read at the rising edge, where the
    // testbench inputs have been stable since the falling edge before it. The register copy
    // follows every write, an accepted item gets its bucket predicted with the size that
    // holds at that moment, and every accepted result is checked against the oldest one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            table_size_now <= SIZE_AT_RESET;
            pair_taken     <= 1'b0;
        end else begin
            if (cfg_we) begin
                table_size_now <= cfg_wdata;
            end
            pair_taken <= item_if.valid && item_if.ready;
            if (item_if.valid && item_if.ready) begin
                expected_buckets.push_back(fnv_bucket(table_size_now, item_if.src_addr,
                                                      item_if.dst_addr));
            end
            if (result_if.valid && result_if.ready) begin
                if (expected_buckets.size() == 0) begin
                    report_mismatch($sformatf("bucket %0d arrived with no item outstanding",
                                              result_if.bucket_index));
                end else if (result_if.bucket_index !== expected_buckets[0]) begin
                    report_mismatch($sformatf("bucket_index %0d, predicted %0d",
                                              result_if.bucket_index, expected_buckets[0]));
                    void'(expected_buckets.pop_front());
                end else begin
                    void'(expected_buckets.pop_front());
                end
            end
        end
    end

    // Item driver. A pending item holds until it is taken. The sender then works in bursts
    // of one to eight items; between bursts it pauses for a random gap, which is zero a third
    // of the time so that back-to-back stretches occur, and otherwise long enough to land
    // anywhere in the block's working window.
    always @(negedge i_clk) begin
        t_flow_pair next_pair;
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else if (item_if.valid && !pair_taken) begin
            // Still waiting for the block to take the current item.
        end else if (gap_left > 0) begin
            item_if.valid <= 1'b0;
            gap_left--;
        end else if (pending_pairs.size() > 0) begin
            next_pair = pending_pairs.pop_front();
            item_if.valid    <= 1'b1;
            item_if.src_addr <= next_pair.src;
            item_if.dst_addr <= next_pair.dst;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 8);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
            end else begin
                burst_left--;
            end
        end else begin
            item_if.valid <= 1'b0;
        end
    end

    // Result receiver. Ready follows a 16-bit repeating pattern that is redrawn every so often:
    // always ready, a random pattern, a single stall slot, or ready in only one slot of sixteen.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = $urandom_range(16, 200);
            case ($urandom_range(0, 3))
                0:       stall_pattern = 16'hFFFF;
                1:       stall_pattern = 16'($urandom);
                2:       stall_pattern = ~(16'h0001 << $urandom_range(0, 15));
                default: stall_pattern = 16'h0001;
            endcase
        end
        stall_left--;
        stall_phase = stall_phase + 4'd1;
        result_if.ready <= i_rst_n && stall_pattern[stall_phase];
    end

    // Returns once every queued item has been driven and taken and its result checked, then
    // waits out DRAIN_CYCLES so that the block is sure to be idle. The check runs at the rising
    // edge, where the driver's falling-edge updates have all settled.
    task automatic wait_until_idle();
        while (pending_pairs.size() > 0 || item_if.valid || expected_buckets.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_table_size(input logic [32:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // One short directed phase: a new table size, one chosen pair and one random pair.
    task automatic corner_phase(input logic [32:0] size, input logic [31:0] src,
                                input logic [31:0] dst);
        write_table_size(size);
        pending_pairs.push_back('{src: src, dst: dst});
        pending_pairs.push_back('{src: $urandom, dst: $urandom});
        wait_until_idle();
    endtask

    // Table sizes for the random phases: empty, tiny, medium, powers of two, any 32-bit
    // value, values beyond the clamp, at or just below 2^32, and the reset value.
    function automatic logic [32:0] pick_table_size();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0:       return 33'd0;
            1:       return 33'($urandom_range(1, 16));
            2:       return 33'd1 << $urandom_range(0, 32);
            3:       return {1'b0, r};
            4:       return {1'b1, r};
            5:       return SIZE_2_POW_32 - 33'($urandom_range(0, 15));
            6:       return 33'($urandom_range(17, 100000));
            default: return SIZE_AT_RESET;
        endcase
    endfunction

    // Address pairs: fully random, flows inside private subnets, many sources toward one
    // server, and near-extreme addresses with one flipped bit.
    function automatic t_flow_pair pick_pair(input logic [31:0] server);
        logic [31:0] a;
        logic [31:0] b;
        a = $urandom;
        b = $urandom;
        case ($urandom_range(0, 3))
            0:       return '{src: a, dst: b};
            1:       return '{src: {16'hC0A8, a[15:0]}, dst: {8'h0A, b[23:0]}};
            2:       return '{src: a, dst: server};
            default: return '{src: {32{a[0]}} ^ (32'd1 << a[12:8]),
                              dst: {32{b[0]}} ^ (32'd1 << b[12:8])};
        endcase
    endfunction

    initial begin
        logic [31:0] server;
        int          phase;
        int          n;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        item_if.valid     = 1'b0;
        item_if.src_addr  = '0;
        item_if.dst_addr  = '0;
        result_if.ready   = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first with the table size the register comes out of reset with.
        pending_pairs.push_back('{src: 32'h0000_0000, dst: 32'h0000_0000});
        pending_pairs.push_back('{src: 32'hFFFF_FFFF, dst: 32'hFFFF_FFFF});
        pending_pairs.push_back('{src: 32'hC0A8_0001, dst: 32'h0A00_0001});
        pending_pairs.push_back('{src: 32'h8000_0000, dst: 32'h0000_0001});
        pending_pairs.push_back('{src: 32'h0000_0001, dst: 32'h8000_0000});
        pending_pairs.push_back('{src: 32'hAAAA_AAAA, dst: 32'h5555_5555});
        pending_pairs.push_back('{src: 32'h1234_5678, dst: 32'h8765_4321});
        wait_until_idle();

        // A zero size acts as one bucket, the extremes of the legal range, sizes above 2^32
        // that are clamped, the largest 32-bit value and a small odd size.
        corner_phase(33'd0,          32'hFFFF_FFFF, 32'h0000_0000);
        corner_phase(33'd1,          32'h0000_0000, 32'hFFFF_FFFF);
        corner_phase(SIZE_2_POW_32,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        corner_phase(33'h1_FFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        corner_phase(33'h1_0000_0001, 32'h5555_5555, 32'hAAAA_AAAA);
        corner_phase(33'h0_FFFF_FFFF, 32'hC0A8_0101, 32'hC0A8_0102);
        corner_phase(33'd3,          32'h7F00_0001, 32'h7F00_0001);

        // Random part: several phases, each with its own table size and a fresh server
        // address for the many-to-one flows.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_table_size(pick_table_size());
            server = $urandom;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                pending_pairs.push_back(pick_pair(server));
            end
            wait_until_idle();
        end

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/fpbh_pkg.sv
sv/fpbh_if.sv
sv/fpbh_mac.sv
sv/fpbh_div.sv
sv/flow_pair_bucket_hash_top.sv
sim/tb_flow_pair_bucket_hash_top.sv
